// ===== rtl/core/tcce_pkg.sv =====
`default_nettype none

package tcce_pkg;

   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 24;
   localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int COPY_CELLS     = SCREEN_COLUMNS * (SCREEN_ROWS - 1);
   localparam int ADDR_W         = $clog2(CELL_COUNT);

   localparam int OP_W   = 3;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CELL_W = CHAR_W + ATTR_W;

   localparam int REQ_BITS = OP_W + CHAR_W + COL_W + ROW_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = CHAR_W + ATTR_W + COL_W + ROW_W + 1;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ATTR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_ATTR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GLYPH      = 2'd2;

   localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'h1F;
   localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'h10;
   localparam logic [CHAR_W-1:0] GLYPH_RST      = 8'h5F;
   localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'h20;

   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(SCREEN_COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
   localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(COPY_CELLS - 1);
   localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(SCREEN_COLUMNS);

   localparam logic [OP_W-1:0] OP_PUT_CUR   = 3'd0;
   localparam logic [OP_W-1:0] OP_PUT_POS   = 3'd1;
   localparam logic [OP_W-1:0] OP_NEWLINE   = 3'd2;
   localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd3;
   localparam logic [OP_W-1:0] OP_READ      = 3'd4;

   localparam int UPC_W = 4;
   typedef logic [UPC_W-1:0] upc_type;

   localparam upc_type U_CLEAR    = upc_type'(0);
   localparam upc_type U_IDLE     = upc_type'(1);
   localparam upc_type U_PUT_CUR  = upc_type'(2);
   localparam upc_type U_PUT_POS  = upc_type'(3);
   localparam upc_type U_NEWLINE  = upc_type'(4);
   localparam upc_type U_BACK     = upc_type'(5);
   localparam upc_type U_READ     = upc_type'(6);
   localparam upc_type U_SC_PRIME = upc_type'(7);
   localparam upc_type U_SC_COPY  = upc_type'(8);
   localparam upc_type U_SC_DRAIN = upc_type'(9);
   localparam upc_type U_SC_FILL  = upc_type'(10);
   localparam upc_type U_DRAW     = upc_type'(11);
   localparam upc_type U_FIN      = upc_type'(12);

   typedef enum logic [2:0] {
      W_NONE, W_ZERO, W_ERASE, W_CHAR_CUR, W_CHAR_POS, W_DRAW, W_COPY, W_BLANK
   } wsel_type;

   typedef enum logic [1:0] {R_NONE, R_TARGET, R_SHIFT} rsel_type;

   typedef enum logic [2:0] {
      CUR_HOLD, CUR_ADV_CUR, CUR_ADV_POS, CUR_NEWLINE, CUR_BACK
   } cur_op_type;

   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_CLR} cnt_op_type;

   typedef enum logic [2:0] {
      J_NEXT, J_GOTO, J_DISPATCH, J_SCROLL_OR_GOTO, J_UNTIL_COPY, J_UNTIL_END, J_FIN
   } jump_type;

   typedef struct packed {
      wsel_type   wsel;
      rsel_type   rsel;
      cur_op_type cur;
      cnt_op_type cnt;
      jump_type   jump;
      upc_type    target;
   } ctrl_type;

   function automatic ctrl_type ucode(input upc_type pc);
      ctrl_type c;
      c = '{W_NONE, R_NONE, CUR_HOLD, CNT_HOLD, J_GOTO, U_IDLE};
      unique case (pc)
         U_CLEAR:    c = '{W_ZERO, R_NONE, CUR_HOLD, CNT_INC, J_UNTIL_END, U_CLEAR};
         U_IDLE:     c = '{W_NONE, R_NONE, CUR_HOLD, CNT_CLR, J_DISPATCH, U_IDLE};
         U_PUT_CUR:  c = '{W_CHAR_CUR, R_NONE, CUR_ADV_CUR, CNT_HOLD, J_SCROLL_OR_GOTO,
                           U_DRAW};
         U_PUT_POS:  c = '{W_CHAR_POS, R_NONE, CUR_ADV_POS, CNT_HOLD, J_SCROLL_OR_GOTO,
                           U_FIN};
         U_NEWLINE:  c = '{W_ERASE, R_NONE, CUR_NEWLINE, CNT_HOLD, J_SCROLL_OR_GOTO,
                           U_DRAW};
         U_BACK:     c = '{W_ERASE, R_NONE, CUR_BACK, CNT_HOLD, J_GOTO, U_DRAW};
         U_READ:     c = '{W_NONE, R_TARGET, CUR_HOLD, CNT_HOLD, J_GOTO, U_FIN};
         U_SC_PRIME: c = '{W_NONE, R_SHIFT, CUR_HOLD, CNT_INC, J_NEXT, U_IDLE};
         U_SC_COPY:  c = '{W_COPY, R_SHIFT, CUR_HOLD, CNT_INC, J_UNTIL_COPY, U_SC_COPY};
         U_SC_DRAIN: c = '{W_COPY, R_NONE, CUR_HOLD, CNT_HOLD, J_NEXT, U_IDLE};
         U_SC_FILL:  c = '{W_BLANK, R_NONE, CUR_HOLD, CNT_INC, J_UNTIL_END, U_SC_FILL};
         U_DRAW:     c = '{W_DRAW, R_NONE, CUR_HOLD, CNT_HOLD, J_NEXT, U_IDLE};
         U_FIN:      c = '{W_NONE, R_NONE, CUR_HOLD, CNT_HOLD, J_FIN, U_IDLE};
         default:    c = '{W_NONE, R_NONE, CUR_HOLD, CNT_HOLD, J_GOTO, U_IDLE};
      endcase
      return c;
   endfunction

   function automatic upc_type entry(input logic [OP_W-1:0] op);
      upc_type pc;
      unique case (op)
         OP_PUT_CUR:   pc = U_PUT_CUR;
         OP_PUT_POS:   pc = U_PUT_POS;
         OP_NEWLINE:   pc = U_NEWLINE;
         OP_BACKSPACE: pc = U_BACK;
         OP_READ:      pc = U_READ;
         default:      pc = U_FIN;
      endcase
      return pc;
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
      return ADDR_W'(r) * ROW_STEP + ADDR_W'(c);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/text_console_cursor_engine.sv =====
`default_nettype none

// Text console engine: a screen store of 80 x 24 character/attribute cells
// (character in the low byte) and a cursor, driven by a small microcode
// program with one control word per step. Each request transaction gives
// exactly one response transaction. Read-cell and put-at-position run their
// own step, then the finish step that loads the response; put-at-cursor,
// newline and backspace put the cursor draw step between; unused opcodes go
// straight to finish. Finish waits while the last response is unaccepted, and
// requests are taken only in idle. The single write port of the screen store
// sets these steps. A scroll runs before the draw step, which put-at-position
// then also steps through: one pass copies 1840 cells up a row at one cell
// per cycle, then blanks the 80 cells of the bottom row. After reset a
// clearing pass zeroes all 1920 cells, during which no request is accepted.
// Configuration writes are taken at any time.

module text_console_cursor_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // opcode, character, column, row
   input  logic [tcce_pkg::REQ_W-1:0]     req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // cell_character, cell_attribute, cursor_column, cursor_row, scrolled
   output logic [tcce_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [tcce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcce_pkg::CSR_W-1:0]     csr_wr_data
);
   import tcce_pkg::*;

   logic [CELL_W-1:0] mem [CELL_COUNT];

   upc_type           upc_ff, upc_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [OP_W-1:0]   op_ff;
   logic [CHAR_W-1:0] ch_ff;
   logic [COL_W-1:0]  tgt_col_ff;
   logic [ROW_W-1:0]  tgt_row_ff;
   logic              draw_ff, draw_in;
   logic              scroll_ff, scroll_in;
   logic [CELL_W-1:0] rd_ff;
   logic [ATTR_W-1:0] text_attr_ff, blank_attr_ff;
   logic [CHAR_W-1:0] glyph_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic [ATTR_W-1:0] rsp_attr_ff;
   logic [COL_W-1:0]  rsp_col_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic              rsp_scroll_ff;

   ctrl_type          ctrl;
   logic              accept;
   logic              in_range;
   logic              will_scroll;
   logic              out_free;
   logic [OP_W-1:0]   req_op;
   logic [ADDR_W-1:0] cur_addr, tgt_addr;
   logic              mem_we;
   logic [ADDR_W-1:0] waddr;
   logic [CELL_W-1:0] wdata;
   logic              rd_en;
   logic [ADDR_W-1:0] raddr;
   logic [COL_W-1:0]  base_col;
   logic [ROW_W-1:0]  base_row;

   assign ctrl       = ucode(upc_ff);
   assign req_tready = (ctrl.jump == J_DISPATCH);
   assign accept     = req_tvalid && req_tready;
   assign req_op     = req_tdata[OP_W-1:0];
   assign in_range   = (tgt_col_ff <= COL_LAST) && (tgt_row_ff <= ROW_LAST);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cur_addr   = cell_addr(cur_row_ff, cur_col_ff);
   assign tgt_addr   = cell_addr(tgt_row_ff, tgt_col_ff);

   // cursor datapath
   always_comb begin
      cur_col_in  = cur_col_ff;
      cur_row_in  = cur_row_ff;
      will_scroll = 1'b0;
      base_col    = cur_col_ff;
      base_row    = cur_row_ff;
      if (ctrl.cur == CUR_ADV_POS) begin
         base_col = tgt_col_ff;
         base_row = tgt_row_ff;
      end
      unique case (ctrl.cur)
         CUR_ADV_CUR, CUR_ADV_POS: begin
            if ((ctrl.cur == CUR_ADV_CUR) || in_range) begin
               if (base_col == COL_LAST) begin
                  cur_col_in = '0;
                  if (base_row == ROW_LAST) begin
                     will_scroll = 1'b1;
                     cur_row_in  = ROW_LAST;
                  end else begin
                     cur_row_in = base_row + 1'b1;
                  end
               end else begin
                  cur_col_in = base_col + 1'b1;
                  cur_row_in = base_row;
               end
            end
         end
         CUR_NEWLINE: begin
            cur_col_in = '0;
            if (cur_row_ff == ROW_LAST) begin
               will_scroll = 1'b1;
               cur_row_in  = ROW_LAST;
            end else begin
               cur_row_in = cur_row_ff + 1'b1;
            end
         end
         CUR_BACK: begin
            if (cur_col_ff != '0) begin
               cur_col_in = cur_col_ff - 1'b1;
            end else if (cur_row_ff != '0) begin
               cur_row_in = cur_row_ff - 1'b1;
               cur_col_in = COL_LAST;
            end
         end
         CUR_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   // store write and read port selection
   always_comb begin
      mem_we = 1'b0;
      waddr  = cur_addr;
      wdata  = {blank_attr_ff, SPACE_CODE};
      unique case (ctrl.wsel)
         W_ZERO: begin
            mem_we = 1'b1;
            waddr  = cnt_ff;
            wdata  = '0;
         end
         W_ERASE: begin
            mem_we = 1'b1;
         end
         W_CHAR_CUR: begin
            mem_we = 1'b1;
            wdata  = {text_attr_ff, ch_ff};
         end
         W_CHAR_POS: begin
            mem_we = in_range;
            waddr  = tgt_addr;
            wdata  = {text_attr_ff, ch_ff};
         end
         W_DRAW: begin
            mem_we = draw_ff;
            wdata  = {text_attr_ff, glyph_ff};
         end
         W_COPY: begin
            mem_we = 1'b1;
            waddr  = cnt_ff - 1'b1;
            wdata  = rd_ff;
         end
         W_BLANK: begin
            mem_we = 1'b1;
            waddr  = cnt_ff;
         end
         W_NONE: begin
         end
         default: begin
         end
      endcase

      rd_en = 1'b0;
      raddr = cnt_ff + ROW_STEP;
      unique case (ctrl.rsel)
         R_TARGET: begin
            rd_en = in_range;
            raddr = tgt_addr;
         end
         R_SHIFT: begin
            rd_en = 1'b1;
         end
         R_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_ff <= mem[raddr];
      end
   end

   // sequencer
   always_comb begin
      upc_in = upc_ff + 1'b1;
      unique case (ctrl.jump)
         J_NEXT:           upc_in = upc_ff + 1'b1;
         J_GOTO:           upc_in = ctrl.target;
         J_DISPATCH:       upc_in = accept ? entry(req_op) : upc_ff;
         J_SCROLL_OR_GOTO: upc_in = will_scroll ? U_SC_PRIME : ctrl.target;
         J_UNTIL_COPY:     upc_in = (cnt_ff == COPY_LAST) ? upc_ff + 1'b1 : ctrl.target;
         J_UNTIL_END:      upc_in = (cnt_ff == CELL_LAST) ? upc_ff + 1'b1 : ctrl.target;
         J_FIN:            upc_in = out_free ? U_IDLE : upc_ff;
         default:          upc_in = U_IDLE;
      endcase

      unique case (ctrl.cnt)
         CNT_INC:  cnt_in = cnt_ff + 1'b1;
         CNT_CLR:  cnt_in = '0;
         CNT_HOLD: cnt_in = cnt_ff;
         default:  cnt_in = cnt_ff;
      endcase

      draw_in   = draw_ff;
      scroll_in = scroll_ff;
      if (accept) begin
         draw_in   = (req_op == OP_PUT_CUR) || (req_op == OP_NEWLINE) ||
                     (req_op == OP_BACKSPACE);
         scroll_in = 1'b0;
      end else if ((ctrl.jump == J_SCROLL_OR_GOTO) && will_scroll) begin
         scroll_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if ((ctrl.jump == J_FIN) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff        <= U_CLEAR;
         cnt_ff        <= '0;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         draw_ff       <= 1'b0;
         scroll_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         text_attr_ff  <= TEXT_ATTR_RST;
         blank_attr_ff <= BLANK_ATTR_RST;
         glyph_ff      <= GLYPH_RST;
      end else begin
         upc_ff       <= upc_in;
         cnt_ff       <= cnt_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         draw_ff      <= draw_in;
         scroll_ff    <= scroll_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_TEXT_ATTR:  text_attr_ff  <= csr_wr_data;
               CSR_BLANK_ATTR: blank_attr_ff <= csr_wr_data;
               CSR_GLYPH:      glyph_ff      <= csr_wr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // request capture and response register
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_op;
         ch_ff      <= req_tdata[OP_W +: CHAR_W];
         tgt_col_ff <= req_tdata[OP_W + CHAR_W +: COL_W];
         tgt_row_ff <= req_tdata[OP_W + CHAR_W + COL_W +: ROW_W];
      end
      if ((ctrl.jump == J_FIN) && out_free) begin
         if ((op_ff == OP_READ) && in_range) begin
            rsp_char_ff <= rd_ff[CHAR_W-1:0];
            rsp_attr_ff <= rd_ff[CELL_W-1:CHAR_W];
         end else begin
            rsp_char_ff <= '0;
            rsp_attr_ff <= '0;
         end
         rsp_col_ff    <= cur_col_ff;
         rsp_row_ff    <= cur_row_ff;
         rsp_scroll_ff <= scroll_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - RSP_BITS)'(0), rsp_scroll_ff, rsp_row_ff, rsp_col_ff,
                        rsp_attr_ff, rsp_char_ff};

endmodule

`default_nettype wire

// ===== dv/tcce_console_checker.sv =====
`timescale 1ns / 1ps

module tcce_console_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // opcode, character, column, row
   input  logic [tcce_pkg::REQ_W-1:0]     req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // cell_character, cell_attribute, cursor_column, cursor_row, scrolled
   input  logic [tcce_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [tcce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tcce_pkg::CSR_W-1:0]     csr_wr_data,
   output int                             mismatches,
   output int                             pending,
   output int                             scroll_count
);
   import tcce_pkg::*;

   // declared high field first so the lowest field lands in bit 0
   typedef struct packed {
      logic              scrolled;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic [ATTR_W-1:0] cell_attr;
      logic [CHAR_W-1:0] cell_char;
   } console_status_type;

   logic [CELL_W-1:0]  screen [CELL_COUNT];
   int unsigned        cur_col;
   int unsigned        cur_row;
   logic [ATTR_W-1:0]  text_attr;
   logic [ATTR_W-1:0]  blank_attr;
   logic [CHAR_W-1:0]  glyph;
   console_status_type status_q [$];
   int                 error_count = 0;
   int                 scrolls = 0;
   int unsigned        rsp_count = 0;

   task automatic write_cell(input int unsigned c, input int unsigned r,
                             input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] attr);
      if (c < SCREEN_COLUMNS && r < SCREEN_ROWS) begin
         screen[r * SCREEN_COLUMNS + c] = {attr, ch};
      end
   endtask

   task automatic shift_rows();
      for (int i = 0; i < COPY_CELLS; i++) begin
         screen[i] = screen[i + SCREEN_COLUMNS];
      end
      for (int c = 0; c < SCREEN_COLUMNS; c++) begin
         write_cell(c, SCREEN_ROWS - 1, SPACE_CODE, blank_attr);
      end
      cur_row = SCREEN_ROWS - 1;
   endtask

   task automatic place_char(input int unsigned c, input int unsigned r,
                             input logic [CHAR_W-1:0] ch, output bit scr);
      scr = 1'b0;
      write_cell(c, r, ch, text_attr);
      cur_col = c + 1;
      cur_row = r;
      if (cur_col >= SCREEN_COLUMNS) begin
         cur_col = 0;
         cur_row++;
      end
      if (cur_row >= SCREEN_ROWS) begin
         shift_rows();
         scr = 1'b1;
      end
   endtask

   task automatic apply_request(input logic [REQ_W-1:0] req, output console_status_type st);
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] ch;
      int unsigned       col;
      int unsigned       row;
      logic [CELL_W-1:0] cell_word;
      bit                in_range;
      bit                scr;
      op       = req[OP_W-1:0];
      ch       = req[OP_W +: CHAR_W];
      col      = 32'(req[OP_W + CHAR_W +: COL_W]);
      row      = 32'(req[OP_W + CHAR_W + COL_W +: ROW_W]);
      in_range = (col < SCREEN_COLUMNS) && (row < SCREEN_ROWS);
      st       = '0;
      scr      = 1'b0;
      case (op)
         OP_PUT_CUR: begin
            write_cell(cur_col, cur_row, SPACE_CODE, blank_attr);
            place_char(cur_col, cur_row, ch, scr);
            write_cell(cur_col, cur_row, glyph, text_attr);
         end
         OP_PUT_POS: begin
            if (in_range) begin
               place_char(col, row, ch, scr);
            end
         end
         OP_NEWLINE: begin
            write_cell(cur_col, cur_row, SPACE_CODE, blank_attr);
            cur_col = 0;
            cur_row++;
            if (cur_row >= SCREEN_ROWS) begin
               shift_rows();
               scr = 1'b1;
            end
            write_cell(cur_col, cur_row, glyph, text_attr);
         end
         OP_BACKSPACE: begin
            write_cell(cur_col, cur_row, SPACE_CODE, blank_attr);
            if (cur_col > 0) begin
               cur_col--;
               write_cell(cur_col, cur_row, SPACE_CODE, text_attr);
            end else if (cur_row > 0) begin
               cur_row--;
               cur_col = SCREEN_COLUMNS - 1;
               write_cell(cur_col, cur_row, SPACE_CODE, text_attr);
            end
            write_cell(cur_col, cur_row, glyph, text_attr);
         end
         OP_READ: begin
            if (in_range) begin
               cell_word    = screen[row * SCREEN_COLUMNS + col];
               st.cell_char = cell_word[CHAR_W-1:0];
               st.cell_attr = cell_word[CELL_W-1:CHAR_W];
            end
         end
         default: begin
         end
      endcase
      st.cursor_col = cur_col[COL_W-1:0];
      st.cursor_row = cur_row[ROW_W-1:0];
      st.scrolled   = scr;
   endtask

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= 10) begin
            $display("mismatch in transaction %0d, %s: expected %0d, got %0d",
                     rsp_count, field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      console_status_type want;
      console_status_type got;
      if (reset) begin
         for (int i = 0; i < CELL_COUNT; i++) begin
            screen[i] = '0;
         end
         cur_col    = 0;
         cur_row    = 0;
         text_attr  = TEXT_ATTR_RST;
         blank_attr = BLANK_ATTR_RST;
         glyph      = GLYPH_RST;
         status_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[RSP_BITS-1:0];
            if (status_q.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected response transaction %0d: %h", rsp_count, rsp_tdata);
               end
            end else begin
               want = status_q.pop_front();
               check_field("cell_character", 32'(want.cell_char), 32'(got.cell_char));
               check_field("cell_attribute", 32'(want.cell_attr), 32'(got.cell_attr));
               check_field("cursor_column", 32'(want.cursor_col), 32'(got.cursor_col));
               check_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
               check_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
            end
            rsp_count++;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TEXT_ATTR:  text_attr  = csr_wr_data;
               CSR_BLANK_ATTR: blank_attr = csr_wr_data;
               CSR_GLYPH:      glyph      = csr_wr_data;
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            apply_request(req_tdata, want);
            status_q.push_back(want);
            if (want.scrolled) begin
               scrolls++;
            end
         end
      end
      mismatches   <= error_count;
      pending      <= status_q.size();
      scroll_count <= scrolls;
   end

endmodule

// ===== dv/tb_text_console_cursor_engine.sv =====
`timescale 1ns / 1ps

module tb_text_console_cursor_engine;
   import tcce_pkg::*;

   localparam int CYCLE_LIMIT = 15_000_000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 258;
   localparam logic [OP_W-1:0] OP_TOP = '1;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   // opcode, character, column, row
   logic [REQ_W-1:0]     req_tdata;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // cell_character, cell_attribute, cursor_column, cursor_row, scrolled
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wr_data;

   int mismatches;
   int pending;
   int scroll_count;
   int idle_pct = 0;
   int stall_left = 0;
   int items_sent = 0;
   int cycle_count = 0;

   text_console_cursor_engine u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   tcce_console_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .mismatches   (mismatches),
      .pending      (pending),
      .scroll_count (scroll_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver back-pressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [CHAR_W-1:0] rnd_char();
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [COL_W-1:0] rnd_col(input int unsigned hi);
      return COL_W'($urandom_range(0, hi));
   endfunction

   function automatic logic [ROW_W-1:0] rnd_row(input int unsigned lo, input int unsigned hi);
      return ROW_W'($urandom_range(lo, hi));
   endfunction

   task automatic send_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                          input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      int gap;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 9);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({row, col, ch, op});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_attrs(input logic [ATTR_W-1:0] text, input logic [ATTR_W-1:0] blank,
                            input logic [CHAR_W-1:0] mark);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_TEXT_ATTR;
      csr_wr_data <= text;
      @(posedge clock);
      csr_index   <= CSR_BLANK_ATTR;
      csr_wr_data <= blank;
      @(posedge clock);
      csr_index   <= CSR_GLYPH;
      csr_wr_data <= mark;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_sequence();
      int kind;
      int n;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         n = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 100) : $urandom_range(1, 12);
         repeat (n) send_op(OP_PUT_CUR, rnd_char(), rnd_col(127), rnd_row(0, 31));
         if ($urandom_range(0, 1) == 0) begin
            send_op(OP_NEWLINE, rnd_char(), rnd_col(127), rnd_row(0, 31));
         end
      end else if (kind < 45) begin
         if ($urandom_range(0, 9) == 0) begin
            send_op(OP_PUT_POS, rnd_char(), rnd_col(127), rnd_row(0, 31));
         end else begin
            send_op(OP_PUT_POS, rnd_char(), rnd_col(SCREEN_COLUMNS - 1),
                    ($urandom_range(0, 3) == 0) ? rnd_row(SCREEN_ROWS - 2, SCREEN_ROWS - 1)
                                                : rnd_row(0, SCREEN_ROWS - 1));
         end
         repeat ($urandom_range(0, 6)) send_op(OP_PUT_CUR, rnd_char(), rnd_col(127),
                                                rnd_row(0, 31));
      end else if (kind < 55) begin
         repeat ($urandom_range(1, 6)) send_op(OP_NEWLINE, rnd_char(), rnd_col(127),
                                                rnd_row(0, 31));
      end else if (kind < 67) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 6);
         repeat (n) send_op(OP_BACKSPACE, rnd_char(), rnd_col(127), rnd_row(0, 31));
      end else if (kind < 87) begin
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 99) < 85) begin
               send_op(OP_READ, rnd_char(), rnd_col(SCREEN_COLUMNS - 1),
                       rnd_row(0, SCREEN_ROWS - 1));
            end else begin
               send_op(OP_READ, rnd_char(), rnd_col(127), rnd_row(0, 31));
            end
         end
      end else begin
         send_op(OP_W'($urandom_range(0, OP_TOP)), rnd_char(), rnd_col(127), rnd_row(0, 31));
      end
   endtask

   initial begin
      int goal;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_TEXT_ATTR;
      csr_wr_data = '0;
      repeat (12) @(posedge clock);
      reset    <= 1'b0;
      idle_pct <= 30;

      // directed: reset attributes, edges of the screen, all opcodes
      send_op(OP_READ, 8'h00, 7'd0, 5'd0);
      send_op(OP_PUT_CUR, 8'h41, 7'd0, 5'd0);
      send_op(OP_PUT_CUR, 8'hFF, 7'd127, 5'd31);
      send_op(OP_PUT_CUR, 8'h00, 7'd0, 5'd0);
      send_op(OP_READ, 8'h00, 7'd0, 5'd0);
      send_op(OP_READ, 8'hFF, 7'd3, 5'd0);
      repeat (3) send_op(OP_BACKSPACE, 8'h00, 7'd0, 5'd0);
      send_op(OP_BACKSPACE, 8'hFF, 7'd127, 5'd31);
      send_op(OP_PUT_POS, 8'h7E, COL_LAST, 5'd0);
      send_op(OP_BACKSPACE, 8'h00, 7'd0, 5'd0);
      send_op(OP_READ, 8'h00, COL_LAST, 5'd0);
      send_op(OP_PUT_POS, 8'h55, COL_W'(SCREEN_COLUMNS), 5'd5);
      send_op(OP_PUT_POS, 8'hAA, 7'd127, 5'd31);
      send_op(OP_READ, 8'h00, COL_W'(SCREEN_COLUMNS), 5'd0);
      send_op(OP_READ, 8'h00, 7'd0, ROW_W'(SCREEN_ROWS));
      send_op(OP_NEWLINE, 8'h00, 7'd0, 5'd0);
      for (int op = OP_READ + 1; op <= OP_TOP; op++) begin
         send_op(OP_W'(op), 8'hFF, 7'd127, 5'd31);
      end
      send_op(OP_PUT_POS, 8'h5A, COL_LAST, ROW_LAST);
      send_op(OP_READ, 8'h00, COL_LAST, ROW_W'(SCREEN_ROWS - 2));
      send_op(OP_READ, 8'h00, 7'd0, ROW_LAST);
      send_op(OP_NEWLINE, 8'h00, 7'd0, 5'd0);
      send_op(OP_PUT_POS, 8'h31, COL_W'(SCREEN_COLUMNS - 2), ROW_LAST);
      send_op(OP_PUT_CUR, 8'h32, 7'd0, 5'd0);

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         if (p == PHASES - 1) begin
            idle_pct <= 0;
         end else begin
            case ($urandom_range(0, 2))
               0:       idle_pct <= 0;
               1:       idle_pct <= 20;
               default: idle_pct <= 50;
            endcase
         end
         case (p)
            0:       set_attrs(8'hFF, 8'h00, 8'hFF);
            1:       set_attrs(8'h00, 8'hFF, 8'h00);
            default: set_attrs(rnd_char(), rnd_char(), rnd_char());
         endcase
         goal = items_sent + PHASE_ITEMS;
         while (items_sent < goal) run_sequence();
      end
      wait_idle();
      repeat (20) @(posedge clock);

      $display("covered %0d transactions (%0d scrolling the screen) under %0d attribute settings",
               items_sent, scroll_count, PHASES + 1);
      if (mismatches == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatches, pending);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
